/* rtl/pkd_pkg.sv */
`timescale 1ns / 1ps
package pkd_pkg;

	typedef logic [4:0]         code_t;
	typedef logic signed [15:0] value_t;

	localparam logic [19:0] LOCK_RESET   = 20'd150000;
	localparam code_t       ROT_CODE     = 5'd16;
	localparam code_t       SW_CODE_BASE = 5'd17;
	localparam code_t       SW_CODE_MAX  = 5'd20;
	localparam value_t      ROT_MAX      = 16'sd32767;
	localparam value_t      ROT_MIN      = -16'sd32768;
	localparam value_t      PRESS_VALUE  = 16'sd1;

	localparam code_t KEY_MAP [16] = '{
		5'd1, 5'd2, 5'd3, 5'd10, 5'd4, 5'd5, 5'd6, 5'd11,
		5'd7, 5'd8, 5'd9, 5'd12, 5'd14, 5'd0, 5'd15, 5'd13
	};

	// event position: keys first, then rotation, then switches
	function automatic code_t event_code_of(input int pos, input int nk);
		code_t c;
		int    row;
		int    col;
		row = pos & 3;
		col = (pos >> 2) & 3;
		if (pos < nk) begin
			if (pos < 16) begin
				c = KEY_MAP[4'((row << 2) + col)];
			end else begin
				c = 5'(pos & 15);
			end
		end else if (pos == nk) begin
			c = ROT_CODE;
		end else begin
			c = SW_CODE_BASE + 5'(pos - nk - 1);
		end
		return c;
	endfunction

endpackage

/* rtl/pkd_lane.sv */
`timescale 1ns / 1ps
module pkd_lane (
	input  logic clk,
	input  logic arst_n,
	input  logic poll,
	input  logic down,
	output logic press
);

	logic held_q;

	assign press = down & ~held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (poll) begin
			held_q <= down;
		end
	end

endmodule

/* rtl/pkd_encoder.sv */
`timescale 1ns / 1ps
module pkd_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample,
	input  logic                clear,
	input  logic                enc_a,
	input  logic                enc_b,
	input  logic [31:0]         time_us,
	input  logic [19:0]         lock_window_us,
	output pkd_pkg::value_t     rot_sum
);

	localparam logic [1:0] PB_UNKNOWN = 2'd2;

	logic            prev_a_q;
	logic [1:0]      prev_b_q;
	logic            locked_q;
	logic [31:0]     deadline_q;
	pkd_pkg::value_t rot_q;

	logic [31:0] diff;
	logic        expired;
	logic        lk;
	logic [1:0]  pb;
	logic [1:0]  b_ext;
	logic        locked_nxt;
	logic [1:0]  prev_b_nxt;
	logic        arm;
	logic        step_up;
	logic        step_dn;
	logic [31:0] deadline_new;

	assign diff         = time_us - deadline_q;
	assign expired      = (diff != 32'd0) && !diff[31];
	assign b_ext        = {1'b0, enc_b};
	assign deadline_new = time_us + {12'd0, lock_window_us};

	always_comb begin
		lk         = locked_q & ~expired;
		pb         = expired ? PB_UNKNOWN : prev_b_q;
		locked_nxt = locked_q;
		prev_b_nxt = prev_b_q;
		arm        = 1'b0;
		step_up    = 1'b0;
		step_dn    = 1'b0;
		if (enc_a != prev_a_q) begin
			if (!enc_a) begin
				locked_nxt = lk;
				prev_b_nxt = pb;
				if (!lk && (b_ext != pb)) begin
					locked_nxt = 1'b1;
					prev_b_nxt = b_ext;
					arm        = 1'b1;
					step_dn    = enc_b;
					step_up    = ~enc_b;
				end
			end else if (!(locked_q && (b_ext == prev_b_q))) begin
				locked_nxt = 1'b0;
				prev_b_nxt = b_ext;
				arm        = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q   <= 1'b1;
			prev_b_q   <= 2'd1;
			locked_q   <= 1'b0;
			deadline_q <= 32'd0;
		end else if (sample) begin
			prev_a_q <= enc_a;
			prev_b_q <= prev_b_nxt;
			locked_q <= locked_nxt;
			if (arm) begin
				deadline_q <= deadline_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= '0;
		end else if (clear) begin
			rot_q <= '0;
		end else if (sample && step_up && (rot_q != pkd_pkg::ROT_MAX)) begin
			rot_q <= rot_q + 16'sd1;
		end else if (sample && step_dn && (rot_q != pkd_pkg::ROT_MIN)) begin
			rot_q <= rot_q - 16'sd1;
		end
	end

	assign rot_sum = rot_q;

endmodule

/* rtl/pkd_merge.sv */
`timescale 1ns / 1ps
module pkd_merge #(
	parameter int NK = 16,
	parameter int NS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [NK+NS:0]    press,
	input  pkd_pkg::value_t   rot_in,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output pkd_pkg::code_t    event_code,
	output pkd_pkg::value_t   event_value,
	output logic              last
);

	localparam int NE = NK + NS + 1;

	logic [NE-1:0]   pend_q;
	pkd_pkg::value_t rot_q;
	logic            valid_q;
	pkd_pkg::code_t  code_q;
	pkd_pkg::value_t value_q;
	logic            last_q;

	logic [NE-1:0]   first;
	logic [NE-1:0]   rest;
	logic            adv;
	logic            emit;
	pkd_pkg::code_t  code_sel;

	assign first = pend_q & (~pend_q + {{(NE-1){1'b0}}, 1'b1});
	assign rest  = pend_q & ~first;
	assign adv   = ~valid_q | out_ready;
	assign emit  = adv & (pend_q != '0);
	assign free  = (pend_q == '0) | (adv & (rest == '0));

	always_comb begin
		code_sel = '0;
		for (int i = 0; i < NE; i++) begin
			if (first[i]) begin
				code_sel = code_sel | pkd_pkg::event_code_of(i, NK);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= press;
			end else if (emit) begin
				pend_q <= rest;
			end
			if (adv) begin
				valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rot_q <= rot_in;
		end
		if (emit) begin
			code_q  <= code_sel;
			value_q <= first[NK] ? rot_q : pkd_pkg::PRESS_VALUE;
			last_q  <= (rest == '0);
		end
	end

	assign out_valid   = valid_q;
	assign event_code  = code_q;
	assign event_value = value_q;
	assign last        = last_q;

endmodule

/* rtl/panel_encoder_keypad_events.sv */
`timescale 1ns / 1ps
// channel  handshake              payload
// in       in_valid / in_ready    operation, enc_a, enc_b, time_us, key_lines, switch_levels
// out      out_valid / out_ready  event_code, event_value, last
// cfg      cfg_valid / cfg_ready  lock_window_us
//
// A sample item is taken every cycle, also while a poll is still emitting; it yields no event.
// Polls load a pending register; events leave it through the single output register of the merge
// stage one per cycle while out_ready is high; the next poll is taken as the last event enters it.
// Reset clears the hold marks, the encoder state, the pending events and sets the window to 150000.
// A stalled out_ready holds the current event; further polls wait while events are still pending, samples keep flowing.
module panel_encoder_keypad_events #(
	parameter int NUM_KEYS     = 16,
	parameter int NUM_SWITCHES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic                enc_a,
	input  logic                enc_b,
	input  logic [31:0]         time_us,
	input  logic [15:0]         key_lines,
	input  logic [3:0]          switch_levels,
	output logic                out_valid,
	input  logic                out_ready,
	output pkd_pkg::code_t      event_code,
	output pkd_pkg::value_t     event_value,
	output logic                last,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [19:0]         lock_window_us
);

	localparam int NE = NUM_KEYS + NUM_SWITCHES + 1;

	logic [19:0]       window_q;
	logic              accept;
	logic              sample;
	logic              poll;
	logic              free;
	logic [NE-1:0]     press;
	pkd_pkg::value_t   rot_sum;

	assign cfg_ready = 1'b1;
	assign in_ready  = ~operation | free;
	assign accept    = in_valid & in_ready;
	assign sample    = accept & ~operation;
	assign poll      = accept & operation;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= pkd_pkg::LOCK_RESET;
		end else if (cfg_valid) begin
			window_q <= lock_window_us;
		end
	end

	pkd_encoder u_enc (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample         (sample),
		.clear          (poll),
		.enc_a          (enc_a),
		.enc_b          (enc_b),
		.time_us        (time_us),
		.lock_window_us (window_q),
		.rot_sum        (rot_sum)
	);

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		logic down;
		if (k < 16) begin : g_line
			assign down = key_lines[k];
		end else begin : g_none
			assign down = 1'b0;
		end
		pkd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.poll   (poll),
			.down   (down),
			.press  (press[k])
		);
	end

	assign press[NUM_KEYS] = (rot_sum != '0);

	for (genvar s = 0; s < NUM_SWITCHES; s++) begin : g_sw
		logic down;
		if (s < 4) begin : g_line
			assign down = ~switch_levels[s];
		end else begin : g_none
			assign down = 1'b0;
		end
		pkd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.poll   (poll),
			.down   (down),
			.press  (press[NUM_KEYS+1+s])
		);
	end

	pkd_merge #(
		.NK (NUM_KEYS),
		.NS (NUM_SWITCHES)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (poll),
		.press       (press),
		.rot_in      (rot_sum),
		.free        (free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_code  (event_code),
		.event_value (event_value),
		.last        (last)
	);

endmodule

/* rtl/pkd_checker.sv */
`timescale 1ns / 1ps
module pkd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                operation,
	input logic                out_valid,
	input logic                out_ready,
	input pkd_pkg::code_t      event_code,
	input pkd_pkg::value_t     event_value,
	input logic                last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_code)
			&& $stable(event_value) && $stable(last))
		else $error("event changed while stalled");

	a_sample_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !operation |-> in_ready)
		else $error("sample item refused");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= pkd_pkg::SW_CODE_MAX)
		else $error("event code out of range");

	a_press_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code != pkd_pkg::ROT_CODE |-> event_value == pkd_pkg::PRESS_VALUE)
		else $error("press event value not one");

	a_rot_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == pkd_pkg::ROT_CODE |-> event_value != 16'sd0)
		else $error("zero rotation event");

endmodule

bind panel_encoder_keypad_events pkd_checker u_pkd_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;

	localparam logic       OP_SAMPLE     = 1'b0;
	localparam logic       OP_POLL       = 1'b1;
	localparam logic [1:0] B_UNKNOWN     = 2'd2;
	localparam int         CYCLE_LIMIT   = 1000000;
	localparam int         DRAIN_LIMIT   = 20000;
	localparam int         SETTLE_CYCLES = 16;
	localparam int         ROT_STEPS     = 12;

	// key code by row*4+col
	localparam pkd_pkg::code_t KEYPAD_CODE [16] = '{
		5'd1, 5'd2, 5'd3, 5'd10, 5'd4, 5'd5, 5'd6, 5'd11,
		5'd7, 5'd8, 5'd9, 5'd12, 5'd14, 5'd0, 5'd15, 5'd13
	};

	typedef struct packed {
		logic        op;
		logic        a;
		logic        b;
		logic [31:0] t;
		logic [15:0] keys;
		logic [3:0]  sw;
	} panel_item_t;

	typedef struct packed {
		pkd_pkg::code_t  code;
		pkd_pkg::value_t value;
		logic            last;
	} panel_event_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                operation;
	logic                enc_a;
	logic                enc_b;
	logic [31:0]         time_us;
	logic [15:0]         key_lines;
	logic [3:0]          switch_levels;
	logic                out_valid;
	logic                out_ready;
	pkd_pkg::code_t      event_code;
	pkd_pkg::value_t     event_value;
	logic                last;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [19:0]         lock_window_us;

	// predicted block state
	logic [19:0]         lock_window;
	logic                enc_prev_a;
	logic [1:0]          enc_prev_b;
	logic                enc_locked;
	logic [31:0]         enc_deadline;
	pkd_pkg::value_t     rot_sum;
	logic [15:0]         keys_held;
	logic [3:0]          switches_held;
	panel_event_t        expected_events [$];
	panel_event_t        want_ev;

	int                  mismatches;
	int                  items_sent;
	int                  idle_odds;
	int                  hold_req;
	int                  hold_cnt;
	int                  stall_cnt;
	int                  cycle_cnt;
	logic [31:0]         now_us;
	logic [15:0]         last_keys;

	panel_encoder_keypad_events u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.enc_a          (enc_a),
		.enc_b          (enc_b),
		.time_us        (time_us),
		.key_lines      (key_lines),
		.switch_levels  (switch_levels),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_code     (event_code),
		.event_value    (event_value),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.lock_window_us (lock_window_us)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40) begin
			$display("%0t: %s", $time, what);
		end
	endtask

	function automatic void predict_item(input panel_item_t it);
		panel_event_t evs [$];
		logic [31:0]  since;
		int           k;
		if (it.op == OP_SAMPLE) begin
			if (it.a == enc_prev_a) return;
			enc_prev_a = it.a;
			if (!it.a) begin
				since = it.t - enc_deadline;
				if (since != '0 && !since[31]) begin
					enc_locked = 1'b0;
					enc_prev_b = B_UNKNOWN;
				end
				if (enc_locked || {1'b0, it.b} == enc_prev_b) return;
				enc_locked = 1'b1;
				if (it.b) begin
					if (rot_sum != pkd_pkg::ROT_MIN) rot_sum = rot_sum - 16'sd1;
				end else if (rot_sum != pkd_pkg::ROT_MAX) begin
					rot_sum = rot_sum + 16'sd1;
				end
			end else begin
				if (enc_locked && {1'b0, it.b} == enc_prev_b) return;
				enc_locked = 1'b0;
			end
			enc_prev_b = {1'b0, it.b};
			enc_deadline = it.t + 32'(lock_window);
			return;
		end
		for (k = 0; k < 16; k++) begin
			if (it.keys[k] && !keys_held[k]) begin
				keys_held[k] = 1'b1;
				evs.push_back(panel_event_t'{KEYPAD_CODE[4'((k % 4) * 4 + k / 4)],
					pkd_pkg::PRESS_VALUE, 1'b0});
			end else if (!it.keys[k]) begin
				keys_held[k] = 1'b0;
			end
		end
		if (rot_sum != 16'sd0) begin
			evs.push_back(panel_event_t'{pkd_pkg::ROT_CODE, rot_sum, 1'b0});
			rot_sum = '0;
		end
		for (k = 0; k < 4; k++) begin
			if (!it.sw[k] && !switches_held[k]) begin
				switches_held[k] = 1'b1;
				evs.push_back(panel_event_t'{pkd_pkg::SW_CODE_BASE + 5'(k),
					pkd_pkg::PRESS_VALUE, 1'b0});
			end else if (it.sw[k]) begin
				switches_held[k] = 1'b0;
			end
		end
		if (evs.size() != 0) evs[evs.size() - 1].last = 1'b1;
		foreach (evs[i]) expected_events.push_back(evs[i]);
	endfunction

	task automatic send_item(input panel_item_t it);
		in_valid <= 1'b1;
		operation <= it.op;
		enc_a <= it.a;
		enc_b <= it.b;
		time_us <= it.t;
		key_lines <= it.keys;
		switch_levels <= it.sw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_item(it);
		items_sent++;
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_sample(input logic a, input logic b, input logic [31:0] t);
		send_item(panel_item_t'{OP_SAMPLE, a, b, t, 16'($urandom()), 4'($urandom())});
	endtask

	task automatic send_poll(input logic [15:0] keys, input logic [3:0] sw);
		send_item(panel_item_t'{OP_POLL, 1'($urandom()), 1'($urandom()), $urandom(), keys, sw});
	endtask

	// drop valid, then hold until every predicted event has arrived or the drain limit is reached
	task automatic wait_drained();
		int n;
		in_valid <= 1'b0;
		n = 0;
		while (expected_events.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (expected_events.size() != 0) begin
			report_mismatch($sformatf("%0d expected events never arrived",
				expected_events.size()));
			expected_events.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [19:0] w);
		cfg_valid <= 1'b1;
		lock_window_us <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		lock_window = w;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] next_time();
		logic [31:0] w;
		w = 32'(lock_window);
		case ($urandom_range(0, 9))
			0: return now_us + $urandom();
			1: return now_us + w;
			2, 3, 4: return now_us + $urandom_range(0, w / 8 + 1);
			default: return now_us + $urandom_range(0, 2 * w + 2);
		endcase
	endfunction

	// one detent of gray code from 11, with an occasional bounce
	task automatic send_detent();
		logic [1:0] path [4];
		int         i;
		if ($urandom_range(0, 1) == 1) path = '{2'b01, 2'b00, 2'b10, 2'b11};
		else path = '{2'b10, 2'b00, 2'b01, 2'b11};
		for (i = 0; i < 4; i++) begin
			if (i > 0 && $urandom_range(0, 4) == 0) begin
				now_us = next_time();
				send_sample(path[i][1], path[i][0], now_us);
				now_us = next_time();
				send_sample(path[i - 1][1], path[i - 1][0], now_us);
			end
			now_us = next_time();
			send_sample(path[i][1], path[i][0], now_us);
		end
	endtask

	task automatic test_encoder_edges();
		idle_odds = 3;
		send_sample(1'b0, 1'b0, 32'd0);
		send_sample(1'b1, 1'b0, 32'd10);
		send_sample(1'b0, 1'b1, 32'd20);
		send_sample(1'b1, 1'b1, 32'd30);
		send_sample(1'b0, 1'b1, 32'd40);
		send_sample(1'b1, 1'b1, 32'd50);
		send_sample(1'b0, 1'b1, 32'd150050);
		send_sample(1'b1, 1'b0, 32'd150060);
		send_sample(1'b0, 1'b0, 32'd300061);
		send_sample(1'b1, 1'b1, 32'hFFFF_FFF0);
		send_sample(1'b0, 1'b0, 32'hFFFF_FFFF);
		send_sample(1'b0, 1'b1, 32'd5);
	endtask

	task automatic test_poll_events();
		send_poll(16'hFFFF, 4'h0);
		send_poll(16'hFFFF, 4'h0);
		send_poll(16'h0000, 4'hF);
		send_poll(16'h8000, 4'h7);
		send_poll(16'h0001, 4'hE);
		send_poll(16'h5AA5, 4'h5);
		wait_drained();
	endtask

	task automatic test_lock_window();
		logic [19:0] windows [4];
		int          i;
		windows = '{20'd0, 20'd1, 20'd1000000, 20'd0};
		windows[3] = 20'($urandom_range(2, 999999));
		idle_odds = 4;
		foreach (windows[w]) begin
			write_window(windows[w]);
			for (i = 0; i < 6; i++) send_detent();
			send_poll(16'($urandom()), 4'($urandom()));
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		int i;
		idle_odds = 0;
		@(negedge clk);
		hold_req = 300;
		@(posedge clk);
		for (i = 0; i < 24; i++) begin
			send_poll(i[0] ? 16'h0000 : 16'hFFFF, i[0] ? 4'hF : 4'h0);
		end
		wait_drained();
		idle_odds = 3;
		for (i = 0; i < 6; i++) begin
			send_poll(16'($urandom()), 4'($urandom()));
			wait_drained();
		end
	endtask

	task automatic test_rotation_steps();
		int i;
		int dir;
		write_window(20'd0);
		idle_odds = 0;
		for (dir = 0; dir < 2; dir++) begin
			for (i = 0; i < ROT_STEPS; i++) begin
				now_us = now_us + 32'd1;
				send_sample(1'b1, dir[0], now_us);
				now_us = now_us + 32'd1;
				send_sample(1'b0, dir[0], now_us);
			end
			send_poll(16'h0000, 4'hF);
			wait_drained();
		end
	endtask

	task automatic test_random_traffic();
		int phase;
		int target;
		for (phase = 0; phase < 3; phase++) begin
			if (phase == 0) write_window(20'($urandom_range(0, 2000)));
			else write_window(20'($urandom_range(0, 1000000)));
			idle_odds = (phase == 1) ? 8 : 3;
			target = items_sent + 40;
			while (items_sent < target) begin
				if (phase == 2 && target - items_sent < 20) idle_odds = 0;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: send_detent();
					6, 7, 8: begin
						case ($urandom_range(0, 3))
							0: last_keys = 16'($urandom());
							1: last_keys = last_keys ^ (16'd1 << $urandom_range(0, 15));
							2: last_keys = '0;
							default: last_keys = last_keys | 16'($urandom());
						endcase
						send_poll(last_keys, 4'($urandom()));
					end
					default: begin
						now_us = now_us + $urandom();
						send_sample(1'($urandom()), 1'($urandom()), now_us);
					end
				endcase
			end
			wait_drained();
		end
	endtask

	// receiver: long hold-off on request, else random stall bursts
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_cnt = hold_req;
			hold_req = 0;
		end
		if (hold_cnt != 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (stall_cnt != 0) begin
			stall_cnt--;
			out_ready <= 1'b0;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			stall_cnt = $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event code %0d value %0d last %0b",
					event_code, event_value, last));
			end else begin
				want_ev = expected_events.pop_front();
				if (event_code !== want_ev.code) begin
					report_mismatch($sformatf("event_code %0d, want %0d",
						event_code, want_ev.code));
				end
				if (event_value !== want_ev.value) begin
					report_mismatch($sformatf("event_value %0d, want %0d (code %0d)",
						event_value, want_ev.value, want_ev.code));
				end
				if (last !== want_ev.last) begin
					report_mismatch($sformatf("last %0b, want %0b (code %0d)",
						last, want_ev.last, want_ev.code));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_SAMPLE;
		enc_a = 1'b1;
		enc_b = 1'b1;
		time_us = '0;
		key_lines = '0;
		switch_levels = 4'hF;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		lock_window_us = '0;
		lock_window = pkd_pkg::LOCK_RESET;
		enc_prev_a = 1'b1;
		enc_prev_b = 2'd1;
		enc_locked = 1'b0;
		enc_deadline = '0;
		rot_sum = '0;
		keys_held = '0;
		switches_held = '0;
		mismatches = 0;
		items_sent = 0;
		idle_odds = 0;
		hold_req = 0;
		hold_cnt = 0;
		stall_cnt = 0;
		cycle_cnt = 0;
		now_us = 32'd400000;
		last_keys = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encoder_edges();
		test_poll_events();
		test_lock_window();
		test_backpressure();
		test_rotation_steps();
		test_random_traffic();
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
